FILE: hw/rtl/lmd_pkg.sv
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types, register codes and helper functions of the led matrix driver.
// ----------------------------------------------------------------------------
package lmd_pkg;

	localparam int ROWS        = 8;
	localparam int ROW_W       = 3;
	localparam int MOD_IDX_W   = 3;
	localparam int CNT_W       = 4;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;
	localparam int INIT_GROUPS = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULE_COUNT = 2'd0,
		REG_ROTATE       = 2'd1,
		REG_BRIGHTNESS   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ACT_PIXEL     = 3'd0,
		ACT_CLEAR     = 3'd1,
		ACT_FLUSH     = 3'd2,
		ACT_INIT      = 3'd3,
		ACT_INTENSITY = 3'd4
	} act_t;

	localparam logic [7:0] DEV_DISPLAY_TEST = 8'h0F;
	localparam logic [7:0] DEV_DECODE_MODE  = 8'h09;
	localparam logic [7:0] DEV_INTENSITY    = 8'h0A;
	localparam logic [7:0] DEV_SCAN_LIMIT   = 8'h0B;
	localparam logic [7:0] DEV_SHUTDOWN     = 8'h0C;
	localparam logic [7:0] PIXEL_MSB        = 8'h80;

	typedef struct packed {
		act_t                 op;
		logic [ROW_W-1:0]     row;
		logic [MOD_IDX_W-1:0] mod_idx;
		logic [7:0]           mask;
		logic                 set;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	function automatic logic [7:0] init_addr(input logic [ROW_W-1:0] g);
		logic [7:0] a;
		case (g)
			3'd0: a = DEV_DISPLAY_TEST;
			3'd1: a = DEV_DECODE_MODE;
			3'd2: a = DEV_INTENSITY;
			3'd3: a = DEV_SCAN_LIMIT;
			default: a = DEV_SHUTDOWN;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] init_val(input logic [ROW_W-1:0] g,
		input logic [7:0] bright);
		logic [7:0] v;
		case (g)
			3'd2: v = bright;
			3'd3: v = 8'h07;
			3'd4: v = 8'h01;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/lmd_front.sv
// ----------------------------------------------------------------------------
// lmd_front
// Accepts input items, drops ignored ones and turns the rest into commands.
// ----------------------------------------------------------------------------
module lmd_front (
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 action,
	input  logic [6:0]                 pixel_x,
	input  logic [3:0]                 pixel_y,
	input  logic                       pixel_value,
	input  logic [lmd_pkg::CNT_W-1:0]  n_eff,
	input  lmd_pkg::q_stat_t           q_stat,
	output logic                       push,
	output lmd_pkg::cmd_t              cmd
);

	logic keep;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && keep;

	always_comb begin
		cmd.op      = lmd_pkg::act_t'(action);
		cmd.row     = pixel_y[lmd_pkg::ROW_W-1:0];
		cmd.mod_idx = pixel_x[3+lmd_pkg::MOD_IDX_W-1:3];
		cmd.mask    = lmd_pkg::PIXEL_MSB >> pixel_x[2:0];
		cmd.set     = pixel_value;
		case (action)
			lmd_pkg::ACT_PIXEL: begin
				keep = ({1'b0, pixel_x[6:3]} < {1'b0, n_eff})
					&& (pixel_y < 4'(lmd_pkg::ROWS));
			end
			lmd_pkg::ACT_CLEAR,
			lmd_pkg::ACT_FLUSH,
			lmd_pkg::ACT_INIT,
			lmd_pkg::ACT_INTENSITY: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

endmodule

FILE: hw/rtl/lmd_fifo.sv
// ----------------------------------------------------------------------------
// lmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lmd_pkg::cmd_t    wr_cmd,
	input  logic             pop,
	output lmd_pkg::cmd_t    rd_cmd,
	output lmd_pkg::q_stat_t stat
);

	lmd_pkg::cmd_t                 q_mem [lmd_pkg::QDEPTH];
	logic [lmd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lmd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lmd_pkg::QCNT_W-1:0]    count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == lmd_pkg::QCNT_W'(lmd_pkg::QDEPTH));
	assign rd_cmd     = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/lmd_back.sv
// ----------------------------------------------------------------------------
// lmd_back
// Executes commands: frame buffer updates and serial word generation.
// ----------------------------------------------------------------------------
module lmd_back #(
	parameter int MAX_MODULES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lmd_pkg::q_stat_t           q_stat,
	input  lmd_pkg::cmd_t              q_cmd,
	output logic                       q_pop,
	input  logic [lmd_pkg::CNT_W-1:0]  n_eff,
	input  logic                       rotate,
	input  logic [7:0]                 brightness,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [15:0]                serial_word,
	output logic                       latch_after,
	output logic                       last
);

	localparam int DEPTH  = lmd_pkg::ROWS * MAX_MODULES;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PIX  = 3'b010,
		ST_GEN  = 3'b100
	} state_t;

	state_t                              state_q;
	lmd_pkg::act_t                       kind_q;
	logic [lmd_pkg::ROW_W-1:0]           grp_q;
	logic [lmd_pkg::MOD_IDX_W-1:0]       idx_q;
	logic [ADDR_W-1:0]                   pix_addr_q;
	logic [7:0]                          pix_mask_q;
	logic                                pix_set_q;

	logic [DEPTH-1:0]                    vld_q;
	logic [7:0]                          fb_mem [DEPTH];
	logic [7:0]                          rd_data_q;
	logic                                rd_hit_q;

	logic                                vld_s1;
	logic [7:0]                          hi_s1;
	logic [7:0]                          cval_s1;
	logic                                mem_s1;
	logic                                rev_s1;
	logic                                latch_s1;
	logic                                last_s1;

	logic                                out_vld_q;
	logic [15:0]                         word_q;
	logic                                latch_q;
	logic                                last_q;

	logic                                out_load;
	logic                                advance;
	logic                                issue;
	logic                                pop_pix;
	logic [lmd_pkg::MOD_IDX_W-1:0]       n_m1;
	logic [lmd_pkg::MOD_IDX_W-1:0]       mod_sel;
	logic                                last_mod;
	logic [lmd_pkg::ROW_W-1:0]           grp_end;
	logic                                last_grp;
	logic [7:0]                          gen_hi;
	logic [7:0]                          gen_val;
	logic                                gen_mem;
	logic                                gen_rev;
	logic                                rd_en;
	logic [ADDR_W-1:0]                   rd_addr;
	logic                                wr_en;
	logic [7:0]                          old_byte;
	logic [7:0]                          wr_data;
	logic [7:0]                          mem_byte;
	logic [7:0]                          s1_val;

	assign out_load = vld_s1 && (!out_vld_q || out_ready);
	assign advance  = !vld_s1 || out_load;
	assign q_pop    = (state_q == ST_IDLE) && !q_stat.empty && !vld_s1;
	assign pop_pix  = q_pop && (q_cmd.op == lmd_pkg::ACT_PIXEL);
	assign issue    = (state_q == ST_GEN) && advance;

	assign n_m1     = lmd_pkg::MOD_IDX_W'(n_eff - 1'b1);
	assign mod_sel  = rotate ? (n_m1 - idx_q) : idx_q;
	assign last_mod = (idx_q == n_m1);
	assign last_grp = (grp_q == grp_end);

	always_comb begin
		grp_end = '0;
		gen_hi  = lmd_pkg::DEV_INTENSITY;
		gen_val = brightness;
		gen_mem = 1'b0;
		gen_rev = 1'b0;
		case (kind_q)
			lmd_pkg::ACT_FLUSH: begin
				grp_end = lmd_pkg::ROW_W'(lmd_pkg::ROWS - 1);
				gen_hi  = rotate ? (8'(lmd_pkg::ROWS) - {5'b0, grp_q})
					: ({5'b0, grp_q} + 8'd1);
				gen_val = 8'h00;
				gen_mem = 1'b1;
				gen_rev = rotate;
			end
			lmd_pkg::ACT_INIT: begin
				grp_end = lmd_pkg::ROW_W'(lmd_pkg::INIT_GROUPS - 1);
				gen_hi  = lmd_pkg::init_addr(grp_q);
				gen_val = lmd_pkg::init_val(grp_q, brightness);
			end
			default: begin
				grp_end = '0;
			end
		endcase
	end

	// frame buffer read port shared by pixel updates and flush
	always_comb begin
		if (pop_pix) begin
			rd_addr = ADDR_W'(int'(q_cmd.row) * MAX_MODULES + int'(q_cmd.mod_idx));
		end else begin
			rd_addr = ADDR_W'(int'(grp_q) * MAX_MODULES + int'(mod_sel));
		end
	end

	assign rd_en    = pop_pix || (issue && (kind_q == lmd_pkg::ACT_FLUSH));
	assign wr_en    = (state_q == ST_PIX);
	assign old_byte = rd_hit_q ? rd_data_q : 8'h00;
	assign wr_data  = pix_set_q ? (old_byte | pix_mask_q) : (old_byte & ~pix_mask_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= fb_mem[rd_addr];
			rd_hit_q  <= vld_q[rd_addr];
		end
		if (wr_en) begin
			fb_mem[pix_addr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (q_pop && ((q_cmd.op == lmd_pkg::ACT_CLEAR)
			|| (q_cmd.op == lmd_pkg::ACT_INIT))) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[pix_addr_q] <= 1'b1;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= lmd_pkg::ACT_FLUSH;
			grp_q      <= '0;
			idx_q      <= '0;
			pix_addr_q <= '0;
			pix_mask_q <= '0;
			pix_set_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_cmd.op)
							lmd_pkg::ACT_PIXEL: begin
								pix_addr_q <= rd_addr;
								pix_mask_q <= q_cmd.mask;
								pix_set_q  <= q_cmd.set;
								state_q    <= ST_PIX;
							end
							lmd_pkg::ACT_FLUSH,
							lmd_pkg::ACT_INIT,
							lmd_pkg::ACT_INTENSITY: begin
								kind_q  <= q_cmd.op;
								grp_q   <= '0;
								idx_q   <= '0;
								state_q <= ST_GEN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PIX: begin
					state_q <= ST_IDLE;
				end
				ST_GEN: begin
					if (issue) begin
						if (last_mod) begin
							idx_q <= '0;
							if (last_grp) begin
								state_q <= ST_IDLE;
							end else begin
								grp_q <= grp_q + 1'b1;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word stage waiting on the buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			hi_s1    <= '0;
			cval_s1  <= '0;
			mem_s1   <= 1'b0;
			rev_s1   <= 1'b0;
			latch_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (advance) begin
			vld_s1 <= issue;
			if (issue) begin
				hi_s1    <= gen_hi;
				cval_s1  <= gen_val;
				mem_s1   <= gen_mem;
				rev_s1   <= gen_rev;
				latch_s1 <= last_mod;
				last_s1  <= last_mod && last_grp;
			end
		end
	end

	assign mem_byte = rd_hit_q ? (rev_s1 ? lmd_pkg::rev8(rd_data_q) : rd_data_q) : 8'h00;
	assign s1_val   = mem_s1 ? mem_byte : cval_s1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			word_q    <= '0;
			latch_q   <= 1'b0;
			last_q    <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
			word_q    <= {hi_s1, s1_val};
			latch_q   <= latch_s1;
			last_q    <= last_s1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid   = out_vld_q;
	assign serial_word = word_q;
	assign latch_after = latch_q;
	assign last        = last_q;

endmodule

FILE: hw/rtl/led_matrix_chain_frame_driver.sv
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_driver
// Frame buffer and command word generator for a chain of 8x8 led modules.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue and are carried out one at a time by
// the back end, which emits at most one serial word per cycle. A pixel write
// reads its byte on pop and writes it in the pixel state; a clear only resets
// the valid bits. A flush emits eight groups of n words, init five and an
// intensity resend one, n being the effective module count. Ignored items
// never enter the queue. Reset clears the buffer at once through per-entry
// valid bits, so there is no clearing pass. Configuration writes must be
// issued only while the block is idle.
module led_matrix_chain_frame_driver #(
	parameter int MAX_MODULES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [2:0]                       action,
	input  logic [6:0]                       pixel_x,
	input  logic [3:0]                       pixel_y,
	input  logic                             pixel_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      serial_word,
	output logic                             latch_after,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [lmd_pkg::CNT_W-1:0] module_count_q;
	logic                      rotate_q;
	logic [7:0]                brightness_q;
	logic [lmd_pkg::CNT_W-1:0] n_eff;

	logic                      q_push;
	logic                      q_pop;
	lmd_pkg::cmd_t             q_wr_cmd;
	lmd_pkg::cmd_t             q_rd_cmd;
	lmd_pkg::q_stat_t          q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_count_q <= lmd_pkg::CNT_W'(1);
			rotate_q       <= 1'b0;
			brightness_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lmd_pkg::REG_MODULE_COUNT: module_count_q <= cfg_data[lmd_pkg::CNT_W-1:0];
				lmd_pkg::REG_ROTATE:       rotate_q       <= cfg_data[0];
				lmd_pkg::REG_BRIGHTNESS:   brightness_q   <= cfg_data[7:0];
				default: begin
					rotate_q <= rotate_q;
				end
			endcase
		end
	end

	// zero counts as one module, large counts saturate
	always_comb begin
		if (module_count_q == '0) begin
			n_eff = lmd_pkg::CNT_W'(1);
		end else if (module_count_q > lmd_pkg::CNT_W'(MAX_MODULES)) begin
			n_eff = lmd_pkg::CNT_W'(MAX_MODULES);
		end else begin
			n_eff = module_count_q;
		end
	end

	lmd_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.n_eff       (n_eff),
		.q_stat      (q_stat),
		.push        (q_push),
		.cmd         (q_wr_cmd)
	);

	lmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.stat   (q_stat)
	);

	lmd_back #(
		.MAX_MODULES (MAX_MODULES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_cmd       (q_rd_cmd),
		.q_pop       (q_pop),
		.n_eff       (n_eff),
		.rotate      (rotate_q),
		.brightness  (brightness_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.serial_word (serial_word),
		.latch_after (latch_after),
		.last        (last)
	);

`ifndef NO_ASSERTIONS
	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command popped from empty queue");

	a_last_is_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> latch_after)
		else $error("final word of a run without latch");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !q_pop) |=> !q_stat.empty)
		else $error("queue lost entries");
`endif

endmodule

FILE: dv/led_matrix_chain_frame_driver_checker.sv
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_driver_checker
// Watches the item, register and serial word channels of the led matrix chain
// driver. It keeps its own frame buffer and copies of the three settings,
// updated from accepted items and register writes. It expands each flush,
// init and intensity item into the words the chain should receive. Every
// accepted output word is compared in order with the oldest of those words.
// ----------------------------------------------------------------------------
module led_matrix_chain_frame_driver_checker
	import lmd_pkg::*;
#(
	parameter int MAX_MODULES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [2:0]            action,
	input  logic [6:0]            pixel_x,
	input  logic [3:0]            pixel_y,
	input  logic                  pixel_value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [15:0]           serial_word,
	input  logic                  latch_after,
	input  logic                  last,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] BLANK            = 8'h00;
	localparam logic [7:0] SCAN_ALL_DIGITS  = 8'h07;
	localparam logic [7:0] NORMAL_OPERATION = 8'h01;
	localparam int         REPORT_LIMIT     = 10;

	typedef struct packed {
		logic [15:0] word;
		logic        latch;
		logic        fin;
	} chain_word_t;

	logic [7:0]  frame [ROWS*MAX_MODULES];
	logic [3:0]  module_count;
	logic        rotate_180;
	logic [7:0]  brightness;
	chain_word_t words_due [$];
	chain_word_t want;
	int          slot;

	function automatic int chain_len();
		if (module_count == 0) return 1;
		if (int'(module_count) > MAX_MODULES) return MAX_MODULES;
		return int'(module_count);
	endfunction

	// one word per module, latch on the last of the group
	function automatic void queue_group(input logic [7:0] addr, input logic [7:0] val,
		input logic fin);
		int n;
		n = chain_len();
		for (int i = 0; i < n; i++) begin
			words_due.push_back('{word: {addr, val}, latch: (i == n - 1),
				fin: (fin && i == n - 1)});
		end
	endfunction

	function automatic void queue_frame();
		int n;
		logic [7:0] addr;
		logic [7:0] row_byte;
		n = chain_len();
		for (int r = 0; r < ROWS; r++) begin
			for (int i = 0; i < n; i++) begin
				if (rotate_180) begin
					addr = 8'(ROWS - r);
					row_byte = {<<{frame[r*MAX_MODULES + n - 1 - i]}};
				end else begin
					addr = 8'(r + 1);
					row_byte = frame[r*MAX_MODULES + i];
				end
				words_due.push_back('{word: {addr, row_byte}, latch: (i == n - 1),
					fin: (r == ROWS - 1 && i == n - 1)});
			end
		end
	endfunction

	function automatic void clear_frame();
		foreach (frame[i]) frame[i] = '0;
	endfunction

	task automatic flag(input string what, input chain_word_t exp_word);
		if (fail_count < REPORT_LIMIT) begin
			$display("%0t %s: expected word %h latch %b last %b, got word %h latch %b last %b",
				$realtime, what, exp_word.word, exp_word.latch, exp_word.fin,
				serial_word, latch_after, last);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			module_count = 4'd1;
			rotate_180   = 1'b0;
			brightness   = 8'd0;
			fail_count   = 0;
			words_due.delete();
			words_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					flag("word with none pending", '0);
				end else begin
					want = words_due.pop_front();
					if (want.word !== serial_word || want.latch !== latch_after ||
						want.fin !== last) begin
						flag("word mismatch", want);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODULE_COUNT) begin
					module_count = cfg_data[3:0];
				end else if (cfg_index == REG_ROTATE) begin
					rotate_180 = cfg_data[0];
				end else if (cfg_index == REG_BRIGHTNESS) begin
					brightness = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				slot = int'(pixel_y) * MAX_MODULES + int'(pixel_x[6:3]);
				case (action)
					ACT_PIXEL: begin
						if (int'(pixel_x[6:3]) < chain_len() && pixel_y < ROWS) begin
							if (pixel_value) begin
								frame[slot] = frame[slot] | (PIXEL_MSB >> pixel_x[2:0]);
							end else begin
								frame[slot] = frame[slot] & ~(PIXEL_MSB >> pixel_x[2:0]);
							end
						end
					end
					ACT_CLEAR: begin
						clear_frame();
					end
					ACT_FLUSH: begin
						queue_frame();
					end
					ACT_INIT: begin
						clear_frame();
						queue_group(DEV_DISPLAY_TEST, BLANK, 1'b0);
						queue_group(DEV_DECODE_MODE, BLANK, 1'b0);
						queue_group(DEV_INTENSITY, brightness, 1'b0);
						queue_group(DEV_SCAN_LIMIT, SCAN_ALL_DIGITS, 1'b0);
						queue_group(DEV_SHUTDOWN, NORMAL_OPERATION, 1'b1);
					end
					ACT_INTENSITY: begin
						queue_group(DEV_INTENSITY, brightness, 1'b1);
					end
					default: begin
					end
				endcase
			end
			words_owed <= words_due.size();
		end
	end

endmodule

FILE: dv/led_matrix_chain_frame_driver_tb.sv
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_driver_tb
// Stimulus and verdict for the led matrix chain driver. A directed part covers
// the field extremes, every action, out of range pixels, unused actions and
// the module count corner values. Random phases follow with changing settings
// and changing idle rates on both sides. One phase holds the receiver off
// while items keep coming, so the block fills up. The checker beside the
// block does all prediction and comparison.
// ----------------------------------------------------------------------------
module led_matrix_chain_frame_driver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lmd_pkg::*;

	localparam int                   MAX_MODULES     = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;
	localparam logic [2:0]           ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0]           ACT_SPARE_LAST  = 3'd7;
	localparam int                   SETTLE_CYCLES   = 20;
	localparam int                   HOLD_OFF_CYCLES = 300;
	localparam int                   STALL_LIMIT     = 5000;
	localparam int                   ITEMS_PER_PHASE = 50;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [2:0]            action;
	logic [6:0]            pixel_x;
	logic [3:0]            pixel_y;
	logic                  pixel_value;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [15:0]           serial_word;
	logic                  latch_after;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    words_owed;

	int tx_idle_pct = 14;
	int rx_idle_pct = 80;
	int chain_n = 1;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	led_matrix_chain_frame_driver #(
		.MAX_MODULES(MAX_MODULES)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.serial_word(serial_word), .latch_after(latch_after), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	led_matrix_chain_frame_driver_checker #(
		.MAX_MODULES(MAX_MODULES)
	) u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.serial_word(serial_word), .latch_after(latch_after), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .words_owed(words_owed)
	);

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (arst_n) begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_action(input logic [2:0] op, input logic [6:0] x,
		input logic [3:0] y, input logic v);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= op;
		pixel_x     <= x;
		pixel_y     <= y;
		pixel_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [7:0] count_byte, input logic rot,
		input logic [7:0] bright);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [7:0]           val [4];
		idx = '{REG_MODULE_COUNT, REG_ROTATE, REG_BRIGHTNESS, REG_SPARE};
		val = '{count_byte, {7'($urandom), rot}, bright, 8'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (count_byte[3:0] == 0) chain_n = 1;
		else if (int'(count_byte[3:0]) > MAX_MODULES) chain_n = MAX_MODULES;
		else chain_n = int'(count_byte[3:0]);
	endtask

	// mostly pixels inside the chain, with flushes often enough to see them
	task automatic random_action(output bit useful);
		int         pick;
		logic [2:0] op;
		logic [6:0] x;
		logic [3:0] y;
		pick   = $urandom_range(99);
		x      = 7'($urandom);
		y      = 4'($urandom);
		useful = 1'b1;
		if (pick < 55) begin
			op = ACT_PIXEL;
			if ($urandom_range(9) != 0) begin
				x = 7'($urandom_range(8 * chain_n - 1));
				y = 4'($urandom_range(ROWS - 1));
			end
			useful = (int'(x[6:3]) < chain_n) && (y < ROWS);
		end else if (pick < 70) begin
			op = ACT_FLUSH;
		end else if (pick < 75) begin
			op = ACT_CLEAR;
		end else if (pick < 80) begin
			op = ACT_INIT;
		end else if (pick < 92) begin
			op = ACT_INTENSITY;
		end else begin
			op = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
			useful = 1'b0;
		end
		send_action(op, x, y, 1'($urandom));
	endtask

	task automatic run_phase(input int goal);
		int done;
		bit useful;
		done = 0;
		while (done < goal) begin
			random_action(useful);
			if (useful) done++;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_PIXEL;
		pixel_x     = '0;
		pixel_y     = '0;
		pixel_value = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_MODULE_COUNT;
		cfg_data    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one module, normal orientation
		send_action(ACT_INIT, 7'd0, 4'd0, 1'b0);
		send_action(ACT_PIXEL, 7'd0, 4'd0, 1'b1);
		send_action(ACT_PIXEL, 7'd7, 4'd7, 1'b1);
		send_action(ACT_PIXEL, 7'd8, 4'd0, 1'b1);
		send_action(ACT_PIXEL, 7'd3, 4'd8, 1'b1);
		send_action(ACT_PIXEL, 7'd127, 4'd15, 1'b1);
		send_action(ACT_PIXEL, 7'd7, 4'd7, 1'b0);
		send_action(ACT_FLUSH, 7'd0, 4'd0, 1'b0);
		send_action(ACT_INTENSITY, 7'd0, 4'd0, 1'b0);
		send_action(ACT_SPARE_FIRST, 7'd127, 4'd15, 1'b1);
		send_action(ACT_SPARE_LAST, 7'd0, 4'd0, 1'b0);
		send_action(ACT_CLEAR, 7'd0, 4'd0, 1'b0);
		send_action(ACT_FLUSH, 7'd0, 4'd0, 1'b0);

		// full chain, rotated, full brightness
		wait_for_quiet();
		write_settings(8'd8, 1'b1, 8'hFF);
		send_action(ACT_PIXEL, 7'd0, 4'd0, 1'b1);
		send_action(ACT_PIXEL, 7'd127, 4'd7, 1'b1);
		send_action(ACT_PIXEL, 7'd63, 4'd3, 1'b1);
		send_action(ACT_PIXEL, 7'd64, 4'd4, 1'b1);
		send_action(ACT_FLUSH, 7'd0, 4'd0, 1'b0);
		send_action(ACT_INTENSITY, 7'd0, 4'd0, 1'b0);
		send_action(ACT_INIT, 7'd0, 4'd0, 1'b0);
		send_action(ACT_PIXEL, 7'd9, 4'd1, 1'b1);
		send_action(ACT_PIXEL, 7'd120, 4'd2, 1'b1);

		// count above the chain saturates, count zero acts as one module
		wait_for_quiet();
		write_settings(8'd15, 1'b0, 8'h00);
		send_action(ACT_FLUSH, 7'd0, 4'd0, 1'b0);
		wait_for_quiet();
		write_settings(8'd0, 1'b1, 8'h5A);
		send_action(ACT_FLUSH, 7'd0, 4'd0, 1'b0);

		wait_for_quiet();
		write_settings(8'($urandom), 1'($urandom), 8'($urandom));
		run_phase(ITEMS_PER_PHASE / 2);
		wait_for_quiet();
		write_settings(8'($urandom), 1'($urandom), 8'($urandom));
		run_phase(ITEMS_PER_PHASE / 2);

		wait_for_quiet();
		tx_idle_pct = 80;
		rx_idle_pct = 14;
		write_settings(8'($urandom), 1'($urandom), 8'($urandom));
		run_phase(ITEMS_PER_PHASE);

		// receiver holds off while items keep coming in
		wait_for_quiet();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_settings(8'd8, 1'($urandom), 8'($urandom));
		hold_requests++;
		for (int i = 0; i < 6; i++) begin
			send_action(ACT_PIXEL, 7'($urandom), 4'($urandom_range(ROWS - 1)), 1'b1);
			send_action(ACT_FLUSH, 7'd0, 4'd0, 1'b0);
		end
		run_phase(ITEMS_PER_PHASE);

		wait_for_quiet();
		if (fail_count == 0 && words_owed == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lmd_pkg.sv
hw/rtl/lmd_front.sv
hw/rtl/lmd_fifo.sv
hw/rtl/lmd_back.sv
hw/rtl/led_matrix_chain_frame_driver.sv
dv/led_matrix_chain_frame_driver_checker.sv
dv/led_matrix_chain_frame_driver_tb.sv
